// ----- hw/rtl/lalc_pkg.sv -----
// ----------------------------------------------------------------------------
// lalc_pkg
// Shared types and constants of the layer age limit calculator: field widths,
// scheme codes, iteration modes and the structs between sequencer, datapath
// and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lalc_pkg;

  // field widths
  localparam int LAYER_W  = 5;
  localparam int GAP_W    = 10;
  localparam int SCHEME_W = 4;
  localparam int AGE_W    = 31;
  localparam int CFG_W    = GAP_W;

  // accumulator wide enough for the exact value: gap times up to 2^31, plus carry
  localparam int ACC_W    = GAP_W + ((1 << LAYER_W) - 1) + 1;

  // multiplier operand of the shift-add mode (square of a layer index)
  localparam int MUL_W    = 2 * LAYER_W;

  // iteration count, one step per layer at most
  localparam int CNT_W    = LAYER_W;

  localparam int NUM_LAYERS_DEF = 32;

  // configuration register indexes
  localparam logic CFG_IDX_SCHEME = 1'b0;
  localparam logic CFG_IDX_GAP    = 1'b1;

  localparam logic [SCHEME_W-1:0] SCHEME_RESET = '0;
  localparam logic [GAP_W-1:0]    GAP_RESET    = GAP_W'(1);

  // aging schemes
  typedef enum logic [SCHEME_W-1:0] {
    SCH_LINEAR  = 4'd0,
    SCH_LINEAR1 = 4'd1,
    SCH_POLY1   = 4'd2,
    SCH_POLY2   = 4'd3,
    SCH_EXP     = 4'd4,
    SCH_EXP2    = 4'd5,
    SCH_EXP3    = 4'd6,
    SCH_FIB     = 4'd7,
    SCH_FIB1    = 4'd8
  } scheme_t;

  // what one step of the shared adder does
  typedef enum logic [1:0] {
    MODE_ADD,   // b = b + a, a holds the gap
    MODE_MUL,   // b = b + (m[0] ? a : 0), a doubles, m halves
    MODE_DBL,   // b = b + b
    MODE_FIB    // b = b + a, a takes old b
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic             load;
    logic             step;
    mode_t            mode;
    logic             dec;
    logic [ACC_W-1:0] init_a;
    logic [ACC_W-1:0] init_b;
    logic [MUL_W-1:0] init_m;
  } dp_ctl_t;

  // sequencer status to top level
  typedef struct packed {
    logic busy;
    logic finish;
    logic bad;
  } seq_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lalc_dp.sv -----
// ----------------------------------------------------------------------------
// lalc_dp
// Datapath: operand registers and the one shared adder that every scheme
// iterates on, plus the saturation check of the final value.
// ----------------------------------------------------------------------------
`default_nettype none

module lalc_dp
  import lalc_pkg::*;
(
  input  wire logic            clk,
  input  wire dp_ctl_t         ctl,
  output logic [AGE_W-1:0]     age,
  output logic                 sat
);

  logic [ACC_W-1:0] a;
  logic [ACC_W-1:0] b;
  logic [MUL_W-1:0] m;
  logic [ACC_W-1:0] opx;
  logic [ACC_W-1:0] opy;
  logic [ACC_W-1:0] sum;

  // operand selection for the shared adder
  always_comb begin
    opx = b;
    case (ctl.mode)
      MODE_ADD: opy = a;
      MODE_MUL: opy = m[0] ? a : '0;
      MODE_DBL: opy = b;
      MODE_FIB: opy = a;
      default:  opy = '0;
    endcase
  end

  // shared adder, optional minus one
  assign sum = opx + opy + {ACC_W{ctl.dec}};

  // operand registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= ctl.init_a;
      b <= ctl.init_b;
      m <= ctl.init_m;
    end else if (ctl.step) begin
      b <= sum;
      case (ctl.mode)
        MODE_MUL: begin
          a <= {a[ACC_W-2:0], 1'b0};
          m <= {1'b0, m[MUL_W-1:1]};
        end
        MODE_FIB: begin
          a <= b;
        end
        default: begin
          a <= a;
        end
      endcase
    end
  end

  // saturate above 2^31-1
  assign sat = |b[ACC_W-1:AGE_W];
  assign age = sat ? {AGE_W{1'b1}} : b[AGE_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/lalc_seq.sv -----
// ----------------------------------------------------------------------------
// lalc_seq
// Sequencer: turns scheme, gap and layer into a start value, a step mode and
// a step count, then runs the shared adder for that many steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lalc_seq
  import lalc_pkg::*;
#(
  parameter int NUM_LAYERS = NUM_LAYERS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [LAYER_W-1:0]  layer,
  input  wire logic [SCHEME_W-1:0] scheme,
  input  wire logic [GAP_W-1:0]    gap,
  output dp_ctl_t                  ctl,
  output seq_stat_t                stat
);

  localparam logic [LAYER_W+1:0] LAST_LAYER = (LAYER_W + 2)'(NUM_LAYERS - 1);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  mode_t              mode;
  logic               dec;
  logic               bad;
  logic               step;

  logic [LAYER_W-1:0] lay;
  logic [MUL_W-1:0]   sq;
  logic [ACC_W-1:0]   g_w;
  logic               load;

  mode_t              plan_mode;
  logic               plan_dec;
  logic               plan_bad;
  logic [CNT_W-1:0]   plan_n;
  logic [ACC_W-1:0]   plan_a;
  logic [ACC_W-1:0]   plan_b;
  logic [MUL_W-1:0]   plan_m;

  // layer beyond the count is clamped to the last layer
  assign lay = ({2'b00, layer} > LAST_LAYER) ? LAST_LAYER[LAYER_W-1:0] : layer;
  assign sq  = MUL_W'(lay) * MUL_W'(lay);
  assign g_w = ACC_W'(gap);

  // per-scheme start values and step plan
  always_comb begin
    plan_mode = MODE_ADD;
    plan_dec  = 1'b0;
    plan_bad  = 1'b0;
    plan_n    = lay;
    plan_a    = g_w;
    plan_b    = g_w;
    plan_m    = '0;
    case (scheme_t'(scheme))
      SCH_LINEAR: begin
        plan_mode = MODE_ADD;
      end
      SCH_LINEAR1: begin
        plan_dec = 1'b1;
      end
      SCH_POLY1: begin
        plan_mode = MODE_MUL;
        plan_n    = CNT_W'(MUL_W);
        plan_b    = '0;
        case (lay)
          LAYER_W'(0): plan_m = MUL_W'(1);
          LAYER_W'(1): plan_m = MUL_W'(2);
          default:     plan_m = sq;
        endcase
      end
      SCH_POLY2: begin
        plan_mode = MODE_MUL;
        plan_n    = CNT_W'(MUL_W);
        case (lay)
          LAYER_W'(0): begin
            plan_m = MUL_W'(1);
            plan_b = (gap > GAP_W'(1)) ? ACC_W'(2) : '0;
          end
          LAYER_W'(1): begin
            plan_m = MUL_W'(2);
            plan_b = ACC_W'(1);
          end
          LAYER_W'(2): begin
            plan_m = MUL_W'(4);
            plan_b = '0;
          end
          LAYER_W'(3): begin
            plan_m = MUL_W'(8);
            plan_b = '0 - ACC_W'(1);
          end
          LAYER_W'(4): begin
            plan_m = MUL_W'(16);
            plan_b = '0 - ACC_W'(3);
          end
          default: begin
            plan_m = sq;
            plan_b = '0;
          end
        endcase
      end
      SCH_EXP: begin
        plan_mode = MODE_DBL;
      end
      SCH_EXP2, SCH_EXP3: begin
        plan_mode = MODE_DBL;
        plan_dec  = 1'b1;
      end
      SCH_FIB: begin
        plan_mode = MODE_FIB;
      end
      SCH_FIB1: begin
        plan_mode = MODE_FIB;
        plan_dec  = 1'b1;
        // small gaps start with b already above two
        if (lay != '0) begin
          if (gap == GAP_W'(1)) begin
            plan_a = ACC_W'(2);
            plan_b = ACC_W'(3);
          end else if (gap == GAP_W'(2)) begin
            plan_a = ACC_W'(2);
            plan_b = ACC_W'(4);
          end
        end
      end
      default: begin
        plan_bad = 1'b1;
        plan_n   = '0;
        plan_b   = '0;
      end
    endcase
  end

  assign load = start && (state == ST_IDLE);

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      mode  <= MODE_ADD;
      dec   <= 1'b0;
      bad   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        mode <= plan_mode;
        dec  <= plan_dec;
        bad  <= plan_bad;
      end
    end
  end

  // next state and step control
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    step       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cnt_next   = plan_n;
          state_next = (plan_n == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        step = 1'b1;
        if (cnt == CNT_W'(1)) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath control
  always_comb begin
    ctl.load   = load;
    ctl.step   = step;
    ctl.mode   = mode;
    ctl.dec    = dec;
    ctl.init_a = plan_a;
    ctl.init_b = plan_b;
    ctl.init_m = plan_m;
  end

  // status to the top level
  always_comb begin
    stat.busy   = (state != ST_IDLE);
    stat.finish = (state == ST_DONE);
    stat.bad    = bad;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/layer_age_limit_calc_unit.sv -----
// ----------------------------------------------------------------------------
// layer_age_limit_calc_unit
// Maximum age of one layer of an age-layered population.
//
// A request is taken at a clock edge with start high and busy low; layer
// gives the layer index. The result (max_age, overflow, invalid_scheme) is
// shown for exactly one cycle with done high; it cannot be held off.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// aging scheme (index 0) and the age gap (index 1); cfg_ready is always high.
// The user makes writes only while no request is in flight; the block itself
// does not enforce it. A request runs the sequencer from idle through n steps
// of the shared adder and a done state back to idle, where the next start
// can be taken; done is registered from the done state. n is the clamped
// layer index (0 to 31) for the linear, doubling and Fibonacci schemes, 10
// for the polynomial schemes (one shift-add step per multiplier bit) and 0
// for an unknown scheme. n is the number of passes through the one shared
// adder of the datapath. A new request is taken while done is still shown.
// Reset clears the sequencer, drops done and sets scheme linear, gap 1.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_age_limit_calc_unit
  import lalc_pkg::*;
#(
  parameter int NUM_LAYERS = NUM_LAYERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [LAYER_W-1:0] layer,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  output logic                    done,
  output logic [AGE_W-1:0]        max_age,
  output logic                    overflow,
  output logic                    invalid_scheme
);

  logic [SCHEME_W-1:0] scheme_reg;
  logic [GAP_W-1:0]    age_gap;
  logic [GAP_W-1:0]    gap_eff;
  dp_ctl_t             ctl;
  seq_stat_t           stat;
  logic [AGE_W-1:0]    age;
  logic                sat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scheme_reg <= SCHEME_RESET;
      age_gap    <= GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_SCHEME: scheme_reg <= cfg_data[SCHEME_W-1:0];
        CFG_IDX_GAP:    age_gap    <= cfg_data[GAP_W-1:0];
        default:        scheme_reg <= scheme_reg;
      endcase
    end
  end

  // zero gap counts as one
  assign gap_eff = (age_gap == '0) ? GAP_W'(1) : age_gap;

  lalc_seq #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .layer  (layer),
    .scheme (scheme_reg),
    .gap    (gap_eff),
    .ctl    (ctl),
    .stat   (stat)
  );

  lalc_dp u_dp (
    .clk (clk),
    .ctl (ctl),
    .age (age),
    .sat (sat)
  );

  assign busy = stat.busy;

  // result register, strobe for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stat.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.finish) begin
      max_age        <= stat.bad ? '0 : age;
      overflow       <= !stat.bad && sat;
      invalid_scheme <= stat.bad;
    end
  end

endmodule

`default_nettype wire
